### rtl/lzss_pkg.sv
// Shared constants for the LZSS stream decoder.
// Depends on nothing; imported by the decoder top level.
`default_nettype none

package lzss_pkg;

  localparam int INDEX_BITS_DEF  = 11;
  localparam int LENGTH_BITS_DEF = 4;
  localparam int BYTE_W          = 8;
  localparam int MAX_RESULTS     = 17;
  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

endpackage

`default_nettype wire

### rtl/lzss_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; used for the decoder's history window.
`default_nettype none

module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/lzss_decoder.sv
// LZSS stream decoder: bit reader, token parser and history window copy engine.
// Depends on lzss_pkg and lzss_ram.
//
//  Port group | Direction | Contents
//  in_*       | sink      | tdata = compressed byte, tlast = end of stream
//  out_*      | source    | tdata = decoded byte, tlast = last byte caused by that item
//
// An item is accepted, its eight compressed bits are decoded in turn, a match's
// bytes are copied from the window, and the last byte is handed over. The single
// window RAM port pair sets the copy rate of one byte per cycle while the output
// register is free or being taken. After reset and after every item marked tlast
// the window is swept back to spaces, all 2^INDEX_BITS entries, during which no
// item is accepted.
// While the output register is full and not being taken, bit decoding and the copy stall.
`default_nettype none

module lzss_decoder
  import lzss_pkg::*;
#(
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [BYTE_W-1:0] in_tdata,   // [7:0] in_byte
  input  wire logic              in_tlast,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [BYTE_W-1:0] out_tdata,  // [7:0] out_byte
  output logic                   out_tlast
);

  localparam int N      = 1 << INDEX_BITS;
  localparam int TOK_W  = INDEX_BITS + LENGTH_BITS;
  localparam int ACC_W  = (TOK_W > BYTE_W) ? TOK_W : BYTE_W;
  localparam int HELD_W = $clog2(ACC_W + 1);
  localparam int RUN_W  = LENGTH_BITS + 1;
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
  localparam int F      = (1 << LENGTH_BITS) + 1;
  localparam logic [INDEX_BITS-1:0] WP_RST = INDEX_BITS'(N - F);

  typedef enum logic [2:0] {S_IDLE, S_BITS, S_COPY, S_FLUSH, S_CLEAR} state_t;
  typedef enum logic [1:0] {PH_FLAG, PH_LIT, PH_MATCH} phase_t;

  state_t                  state_r, state_nxt;
  phase_t                  phase_r, phase_nxt;
  logic [BYTE_W-1:0]       sr_r, sr_nxt;
  logic [3:0]              bitcnt_r, bitcnt_nxt;
  logic                    last_r, last_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [HELD_W-1:0]       held_r, held_nxt;
  logic [INDEX_BITS-1:0]   wp_r, wp_nxt;
  logic [INDEX_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [RUN_W-1:0]        rd_left_r, rd_left_nxt;
  logic [RUN_W-1:0]        wr_left_r, wr_left_nxt;
  logic                    dv_r, dv_nxt;
  logic                    fwd_r, fwd_nxt;
  logic [BYTE_W-1:0]       fwd_d_r, fwd_d_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    p_valid_r, p_valid_nxt;
  logic [BYTE_W-1:0]       p_byte_r, p_byte_nxt;
  logic                    o_valid_r, o_valid_nxt;
  logic [BYTE_W-1:0]       o_byte_r, o_byte_nxt;
  logic                    o_last_r, o_last_nxt;
  logic [INDEX_BITS-1:0]   clr_r, clr_nxt;

  logic                    go;
  logic                    bit_in;
  logic                    adv;
  logic                    wr;
  logic [ACC_W-1:0]        acc_sh;
  logic [HELD_W-1:0]       held_inc;
  logic                    emit_v;
  logic [BYTE_W-1:0]       emit_d;
  logic                    ram_we;
  logic [INDEX_BITS-1:0]   ram_waddr;
  logic [BYTE_W-1:0]       ram_wd;
  logic                    ram_re;
  logic [BYTE_W-1:0]       ram_rd;

  lzss_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (N)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wd),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rd)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = o_valid_r;
  assign out_tdata  = o_byte_r;
  assign out_tlast  = o_last_r;

  // The output register is free, or is being emptied this cycle.
  assign go = !o_valid_r || out_tready;

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    sr_nxt      = sr_r;
    bitcnt_nxt  = bitcnt_r;
    last_nxt    = last_r;
    acc_nxt     = acc_r;
    held_nxt    = held_r;
    wp_nxt      = wp_r;
    rd_ptr_nxt  = rd_ptr_r;
    rd_left_nxt = rd_left_r;
    wr_left_nxt = wr_left_r;
    dv_nxt      = dv_r;
    fwd_nxt     = fwd_r;
    fwd_d_nxt   = fwd_d_r;
    cnt_nxt     = cnt_r;
    p_valid_nxt = p_valid_r;
    p_byte_nxt  = p_byte_r;
    o_valid_nxt = o_valid_r && !out_tready;
    o_byte_nxt  = o_byte_r;
    o_last_nxt  = o_last_r;
    clr_nxt     = clr_r;
    bit_in      = sr_r[BYTE_W-1];
    acc_sh      = {acc_r[ACC_W-2:0], bit_in};
    held_inc    = held_r + HELD_W'(1);
    adv         = 1'b0;
    wr          = 1'b0;
    emit_v      = 1'b0;
    emit_d      = '0;
    ram_we      = 1'b0;
    ram_waddr   = wp_r;
    ram_wd      = SPACE_CHAR;
    ram_re      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          sr_nxt     = in_tdata;
          last_nxt   = in_tlast;
          bitcnt_nxt = '0;
          cnt_nxt    = '0;
          state_nxt  = S_BITS;
        end
      end
      S_BITS: begin
        if (go) begin
          sr_nxt     = {sr_r[BYTE_W-2:0], 1'b0};
          bitcnt_nxt = bitcnt_r + 4'd1;
          state_nxt  = (bitcnt_r == 4'd7) ? S_FLUSH : S_BITS;
          case (phase_r)
            PH_FLAG: begin
              phase_nxt = bit_in ? PH_LIT : PH_MATCH;
              acc_nxt   = '0;
              held_nxt  = '0;
            end
            PH_LIT: begin
              acc_nxt  = acc_sh;
              held_nxt = held_inc;
              if (held_inc == HELD_W'(BYTE_W)) begin
                emit_v    = 1'b1;
                emit_d    = acc_sh[BYTE_W-1:0];
                phase_nxt = PH_FLAG;
                acc_nxt   = '0;
                held_nxt  = '0;
              end
            end
            PH_MATCH: begin
              acc_nxt  = acc_sh;
              held_nxt = held_inc;
              if (held_inc == HELD_W'(TOK_W)) begin
                rd_ptr_nxt  = acc_sh[LENGTH_BITS +: INDEX_BITS];
                rd_left_nxt = RUN_W'(acc_sh[LENGTH_BITS-1:0]) + RUN_W'(2);
                wr_left_nxt = RUN_W'(acc_sh[LENGTH_BITS-1:0]) + RUN_W'(2);
                dv_nxt      = 1'b0;
                fwd_nxt     = 1'b0;
                state_nxt   = S_COPY;
                phase_nxt   = PH_FLAG;
                acc_nxt     = '0;
                held_nxt    = '0;
              end
            end
            default: begin
              phase_nxt = PH_FLAG;
            end
          endcase
        end
      end
      S_COPY: begin
        // Reads run one byte ahead of writes. A read that hits the entry being
        // written in the same cycle takes the written byte from the bypass.
        adv = !dv_r || go;
        wr  = dv_r && go;
        if (wr) begin
          emit_v      = 1'b1;
          emit_d      = fwd_r ? fwd_d_r : ram_rd;
          wr_left_nxt = wr_left_r - RUN_W'(1);
          if (wr_left_r == RUN_W'(1)) begin
            state_nxt = (bitcnt_r == 4'd8) ? S_FLUSH : S_BITS;
          end
        end
        if (adv) begin
          ram_re    = (rd_left_r != '0);
          dv_nxt    = ram_re;
          fwd_nxt   = ram_re && wr && (rd_ptr_r == wp_r);
          fwd_d_nxt = emit_d;
          if (ram_re) begin
            rd_ptr_nxt  = rd_ptr_r + INDEX_BITS'(1);
            rd_left_nxt = rd_left_r - RUN_W'(1);
          end
        end
      end
      S_FLUSH: begin
        if (!p_valid_r || go) begin
          if (p_valid_r) begin
            o_valid_nxt = 1'b1;
            o_byte_nxt  = p_byte_r;
            o_last_nxt  = 1'b1;
            p_valid_nxt = 1'b0;
          end
          if (last_r) begin
            state_nxt = S_CLEAR;
            clr_nxt   = '0;
            wp_nxt    = WP_RST;
            phase_nxt = PH_FLAG;
            acc_nxt   = '0;
            held_nxt  = '0;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wd    = SPACE_CHAR;
        clr_nxt   = clr_r + INDEX_BITS'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Every decoded byte enters the window; only the first MAX_RESULTS of an item are
    // passed on. The newest one waits in the pending register until it is known
    // whether it closes the item's run.
    if (emit_v) begin
      ram_we    = 1'b1;
      ram_waddr = wp_r;
      ram_wd    = emit_d;
      wp_nxt    = wp_r + INDEX_BITS'(1);
      if (cnt_r < CNT_W'(MAX_RESULTS)) begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (p_valid_r) begin
          o_valid_nxt = 1'b1;
          o_byte_nxt  = p_byte_r;
          o_last_nxt  = 1'b0;
        end
        p_byte_nxt  = emit_d;
        p_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      phase_r   <= PH_FLAG;
      bitcnt_r  <= '0;
      last_r    <= 1'b0;
      acc_r     <= '0;
      held_r    <= '0;
      wp_r      <= WP_RST;
      rd_left_r <= '0;
      wr_left_r <= '0;
      dv_r      <= 1'b0;
      fwd_r     <= 1'b0;
      cnt_r     <= '0;
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
      clr_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      bitcnt_r  <= bitcnt_nxt;
      last_r    <= last_nxt;
      acc_r     <= acc_nxt;
      held_r    <= held_nxt;
      wp_r      <= wp_nxt;
      rd_left_r <= rd_left_nxt;
      wr_left_r <= wr_left_nxt;
      dv_r      <= dv_nxt;
      fwd_r     <= fwd_nxt;
      cnt_r     <= cnt_nxt;
      p_valid_r <= p_valid_nxt;
      o_valid_r <= o_valid_nxt;
      clr_r     <= clr_nxt;
    end
    sr_r     <= sr_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    fwd_d_r  <= fwd_d_nxt;
    p_byte_r <= p_byte_nxt;
    o_byte_r <= o_byte_nxt;
    o_last_r <= o_last_nxt;
  end

  // Nothing may still be pending once a new item can be taken.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !p_valid_r)
    else $error("pending byte left over at idle");

  // The bypass is only ever armed alongside a read in flight.
  a_fwd_needs_read: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> dv_r)
    else $error("bypass armed without a read in flight");

  // A copy never runs with nothing left to write.
  a_copy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COPY |-> wr_left_r != '0)
    else $error("copy state with no bytes left");

  // The per-item result count never passes the cap.
  a_cnt_capped: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("result count beyond cap");

  // An accepted item starts bit decoding in the next cycle.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_BITS)
    else $error("accepted item did not start decoding");

endmodule

`default_nettype wire

### tb/sv/lzss_decoder_tb.sv
// Self-checking testbench for lzss_decoder: compressed bytes are fed on the in_ stream,
// decoded bytes are compared item by item against a local bit-level model or typed rows.
// Depends on lzss_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module lzss_decoder_tb;
  import lzss_pkg::*;

  localparam int WIN_N      = 1 << INDEX_BITS_DEF;
  localparam int LOOKAHEAD  = (1 << LENGTH_BITS_DEF) + 1;
  localparam int TOKEN_BITS = INDEX_BITS_DEF + LENGTH_BITS_DEF;
  localparam int RAND_ITEMS = 330;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int N_DIR      = 21;

  typedef enum logic [1:0] {AWAIT_FLAG, READ_LITERAL, READ_MATCH} token_phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_item_t;

  // Directed rows: where typed is set, n copies of val are expected, the final one
  // marked last; otherwise the local model supplies the expectation.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              typed;
    logic [4:0]        n;
    logic [BYTE_W-1:0] val;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},  // match flag, first position bits
    '{8'h00, 1'b0, 1'b1, 5'd2,  8'h20},  // shortest match from the blank window
    '{8'hFF, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'hFF, 1'b0, 1'b1, 5'd1,  8'hFF},  // literal 0xFF, next literal begins
    '{8'h03, 1'b0, 1'b0, 5'd0,  8'h00},
    '{8'hA5, 1'b0, 1'b0, 5'd0,  8'h00},
    '{8'h5A, 1'b0, 1'b0, 5'd0,  8'h00},
    '{8'h80, 1'b1, 1'b0, 5'd0,  8'h00},  // stream end with a token half read
    '{8'h7F, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'hFF, 1'b0, 1'b1, 5'd17, 8'h20},  // longest match at the top position
    '{8'h80, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'h00, 1'b0, 1'b1, 5'd1,  8'h00},  // literal 0x00
    '{8'h55, 1'b0, 1'b0, 5'd0,  8'h00},
    '{8'hAA, 1'b0, 1'b0, 5'd0,  8'h00},
    '{8'hFF, 1'b1, 1'b0, 5'd0,  8'h00},
    '{8'hFF, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'h80, 1'b0, 1'b1, 5'd1,  8'hFF},
    '{8'h0F, 1'b0, 1'b0, 5'd0,  8'h00},
    '{8'h00, 1'b1, 1'b0, 5'd0,  8'h00},
    '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'h0F, 1'b1, 1'b1, 5'd17, 8'h20}   // item with stream end that still completes a match
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [BYTE_W-1:0] in_tdata = '0;   // [7:0] in_byte
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [BYTE_W-1:0] out_tdata;       // [7:0] out_byte
  logic              out_tlast;

  // Local copy of the decoder state.
  logic [BYTE_W-1:0]         hist_win [WIN_N];
  logic [INDEX_BITS_DEF-1:0] hist_wptr;
  logic [15:0]               bit_acc;
  int                        bits_held;
  token_phase_t              phase;

  out_item_t decoded_run[$];
  out_item_t expected_q[$];
  out_item_t head_item;
  int        errors = 0;
  int        results_seen = 0;
  int        cycles = 0;
  bit        tx_steady = 1'b0;
  bit        rx_steady = 1'b0;
  bit        held_off = 1'b0;

  lzss_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void clear_history();
    for (int i = 0; i < WIN_N; i++) hist_win[i] = SPACE_CHAR;
    hist_wptr = INDEX_BITS_DEF'(WIN_N - LOOKAHEAD);
    bit_acc   = '0;
    bits_held = 0;
    phase     = AWAIT_FLAG;
  endfunction

  function automatic void put_byte(input logic [BYTE_W-1:0] c);
    hist_win[hist_wptr] = c;
    hist_wptr = hist_wptr + INDEX_BITS_DEF'(1);
    if (decoded_run.size() < MAX_RESULTS) decoded_run.push_back('{data: c, last: 1'b0});
  endfunction

  // Decodes one compressed byte, MSB first, into decoded_run.
  function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic end_of_stream);
    logic [INDEX_BITS_DEF-1:0]  pos;
    logic [LENGTH_BITS_DEF-1:0] len;
    logic [INDEX_BITS_DEF-1:0]  rd;
    decoded_run.delete();
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (phase == AWAIT_FLAG) begin
        phase = b[i] ? READ_LITERAL : READ_MATCH;
        bit_acc = '0;
        bits_held = 0;
      end else begin
        bit_acc = {bit_acc[14:0], b[i]};
        bits_held++;
        if (phase == READ_LITERAL && bits_held == 8) begin
          put_byte(bit_acc[7:0]);
          phase = AWAIT_FLAG;
        end else if (phase == READ_MATCH && bits_held == TOKEN_BITS) begin
          len = bit_acc[LENGTH_BITS_DEF-1:0];
          pos = bit_acc[TOKEN_BITS-1:LENGTH_BITS_DEF];
          // The copy may read bytes that this same match has just written.
          for (int k = 0; k <= int'(len) + 1; k++) begin
            rd = pos + INDEX_BITS_DEF'(k);
            put_byte(hist_win[rd]);
          end
          phase = AWAIT_FLAG;
        end
      end
    end
    if (decoded_run.size() > 0) decoded_run[decoded_run.size()-1].last = 1'b1;
    if (end_of_stream) clear_history();
  endfunction

  task automatic feed(input logic [BYTE_W-1:0] d, input logic l, input logic typed,
                      input int n, input logic [BYTE_W-1:0] val);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    if ($urandom_range(0, 24) == 0) tx_steady = !tx_steady;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    decode_byte(d, l);
    if (typed) begin
      decoded_run.delete();
      for (int i = 0; i < n; i++) decoded_run.push_back('{data: val, last: (i == n - 1)});
    end
    foreach (decoded_run[i]) expected_q.push_back(decoded_run[i]);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, got data %02h last %0b",
                 $time, out_tdata, out_tlast);
      end else begin
        head_item = expected_q.pop_front();
        if (out_tdata !== head_item.data) begin
          errors++;
          $display("%0t: data mismatch, expected %02h, got %02h",
                   $time, head_item.data, out_tdata);
        end
        if (out_tlast !== head_item.last) begin
          errors++;
          $display("%0t: last mismatch, expected %0b, got %0b",
                   $time, head_item.last, out_tlast);
        end
      end
    end
  end

  // Result side: random back-pressure, with one long hold-off to fill the block.
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (!held_off && results_seen >= 80) begin
        gap = 400;
        held_off = 1'b1;
      end else begin
        gap = rx_steady ? 0 : $urandom_range(0, 5);
        if ($urandom_range(0, 24) == 0) rx_steady = !rx_steady;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    bit                        gen_bits[$];
    logic [INDEX_BITS_DEF-1:0] gen_wptr;
    logic [INDEX_BITS_DEF-1:0] mpos;
    logic [LENGTH_BITS_DEF-1:0] mlen;
    logic [BYTE_W-1:0]         lit;
    logic [BYTE_W-1:0]         packed_b;
    int                        ntok;
    int                        nbytes;
    int                        sent;
    bit                        close_stream;

    clear_history();
    sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIR; r++)
      feed(DIR_ROWS[r].data, DIR_ROWS[r].last, DIR_ROWS[r].typed,
           int'(DIR_ROWS[r].n), DIR_ROWS[r].val);

    while (sent < RAND_ITEMS) begin
      gen_bits.delete();
      gen_wptr = INDEX_BITS_DEF'(WIN_N - LOOKAHEAD);
      if ($urandom_range(0, 4) != 0) begin
        // Well-formed stream of tokens, matches mostly pointing at recent output.
        ntok = $urandom_range(1, 12);
        repeat (ntok) begin
          if ($urandom_range(0, 2) == 0) begin
            lit = BYTE_W'($urandom_range(0, 255));
            gen_bits.push_back(1'b1);
            for (int j = BYTE_W - 1; j >= 0; j--) gen_bits.push_back(lit[j]);
            gen_wptr = gen_wptr + INDEX_BITS_DEF'(1);
          end else begin
            mlen = ($urandom_range(0, 3) == 0) ? '1 :
                   LENGTH_BITS_DEF'($urandom_range(0, 15));
            if ($urandom_range(0, 2) == 0)
              mpos = INDEX_BITS_DEF'($urandom_range(0, WIN_N - 1));
            else
              mpos = gen_wptr - INDEX_BITS_DEF'(1) - INDEX_BITS_DEF'($urandom_range(0, 40));
            gen_bits.push_back(1'b0);
            for (int j = INDEX_BITS_DEF - 1; j >= 0; j--) gen_bits.push_back(mpos[j]);
            for (int j = LENGTH_BITS_DEF - 1; j >= 0; j--) gen_bits.push_back(mlen[j]);
            gen_wptr = gen_wptr + INDEX_BITS_DEF'(mlen) + INDEX_BITS_DEF'(2);
          end
        end
        // Now and then the tail is cut short, leaving a broken last token.
        if ($urandom_range(0, 5) == 0)
          repeat ($urandom_range(1, 12)) if (gen_bits.size() > 1) void'(gen_bits.pop_back());
        while (gen_bits.size() % 8 != 0) gen_bits.push_back(1'($urandom_range(0, 1)));
        nbytes = gen_bits.size() / 8;
        close_stream = 1'b1;
      end else begin
        nbytes = $urandom_range(1, 6);
        repeat (nbytes * 8) gen_bits.push_back(1'($urandom_range(0, 1)));
        close_stream = 1'($urandom_range(0, 1));
      end
      for (int b = 0; b < nbytes; b++) begin
        for (int j = 0; j < 8; j++) packed_b[7-j] = gen_bits[b*8 + j];
        feed(packed_b, close_stream && (b == nbytes - 1), 1'b0, 0, '0);
        sent++;
      end
    end

    @(posedge clk);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
